// ===== design/mwm_pkg.sv =====
// shared types, codes and constants for the mecanum wheel mixer
// used by every module of the block except mwm_div; depends on nothing
package mwm_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int DUTY_MAX_DEF  = 255;

  // |f + s + r| of three 16-bit values fits 17 bits unsigned, 18 bits signed
  localparam int MAG_W     = 17;
  localparam int SUM_W     = 18;
  localparam int WHEELS    = 4;
  localparam int TIMEOUT_W = 16;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  // register index taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [1:0] OP_MIX  = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] forward_speed;
    logic signed [15:0] rotate_speed;
    logic signed [15:0] strafe_speed;
    logic [2:0]         wheel_index;
    logic signed [15:0] wheel_speed;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] fl_fwd_duty;
    logic [7:0] fl_rev_duty;
    logic [7:0] fr_fwd_duty;
    logic [7:0] fr_rev_duty;
    logic [7:0] rl_fwd_duty;
    logic [7:0] rl_rev_duty;
    logic [7:0] rr_fwd_duty;
    logic [7:0] rr_rev_duty;
    logic       watchdog_stopped;
    logic       index_ignored;
  } duty_item_t;

  typedef struct packed {
    logic       capture;
    logic       scan;
    logic       mul;
    logic       div_start;
    logic       write_wheel;
    logic       apply;
    logic       emit;
    logic [1:0] wheel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       index_ok;
    logic [1:0] sel;
    logic       div_done;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== design/mwm_div.sv =====
// restoring divider, one quotient bit per cycle
// no package use; the caller guarantees num < den * 2^QW
module mwm_div #(
  parameter int NW = 25,
  parameter int DW = 17,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [QW-1:0] numlo;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem, numlo[QW-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NW-1:QW];
      numlo <= num[QW-1:0];
      dvs   <= den;
      quot  <= '0;
    end else if (busy) begin
      rem   <= take ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      numlo <= numlo << 1;
      quot  <= {quot[QW-2:0], take};
    end
  end

endmodule

// ===== design/mwm_datapath.sv =====
// mixer datapath: wheel lanes, max scan, duty multiply, shared divider,
// wheel state, idle counter and output register; uses mwm_pkg and mwm_div
module mwm_datapath #(
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF,
  parameter int DUTY_MAX  = mwm_pkg::DUTY_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mwm_pkg::ctrl_cmd_t                 ctl,
  output mwm_pkg::dp_status_t                status,
  input  mwm_pkg::cmd_item_t                 cmd,
  input  logic [mwm_pkg::TIMEOUT_W-1:0]      timeout,
  output logic                               duty_valid,
  input  logic                               duty_stall,
  output mwm_pkg::duty_item_t                duty
);

  localparam int MW = mwm_pkg::MAG_W;
  localparam int SW = mwm_pkg::SUM_W;
  localparam int TW = mwm_pkg::TIMEOUT_W;
  localparam int QW = $clog2(DUTY_MAX + 1);
  localparam int NW = MW + QW;
  localparam logic [MW-1:0]        ONE   = MW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]        DMAX  = QW'(DUTY_MAX);

  logic [1:0]              op_r;
  logic [2:0]              idx_r;
  logic signed [SW-1:0]    lane [mwm_pkg::WHEELS];
  logic [MW-1:0]           m;
  logic [NW-1:0]           prod;
  logic [QW-1:0]           wduty [mwm_pkg::WHEELS];
  logic                    wrev [mwm_pkg::WHEELS];
  logic [TW-1:0]           idle_ticks;
  logic                    wd_fired;
  logic                    ignored;
  logic                    div_done;
  logic [QW-1:0]           quot;

  logic signed [SW-1:0]    f, r, s, ws, ws_clamp, sel_lane, sel_neg;
  logic [MW-1:0]           sel_mag;
  logic [TW:0]             tick_next;
  logic                    out_free;

  assign f  = {{(SW-16){cmd.forward_speed[15]}}, cmd.forward_speed};
  assign r  = {{(SW-16){cmd.rotate_speed[15]}}, cmd.rotate_speed};
  assign s  = {{(SW-16){cmd.strafe_speed[15]}}, cmd.strafe_speed};
  assign ws = {{(SW-16){cmd.wheel_speed[15]}}, cmd.wheel_speed};

  always_comb begin
    ws_clamp = ws;
    if (ws > ONE_S) ws_clamp = ONE_S;
    if (ws < -ONE_S) ws_clamp = -ONE_S;
  end

  assign sel_lane  = lane[ctl.wheel];
  assign sel_neg   = -sel_lane;
  assign sel_mag   = sel_lane[SW-1] ? sel_neg[MW-1:0] : sel_lane[MW-1:0];
  assign tick_next = {1'b0, idle_ticks} + 1'b1;
  assign out_free  = !duty_valid || !duty_stall;

  assign status.op       = op_r;
  assign status.index_ok = !idx_r[2];
  assign status.sel      = idx_r[1:0];
  assign status.div_done = div_done;
  assign status.out_free = out_free;

  // item capture, lane setup, max scan and duty multiply
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= cmd.operation;
      idx_r <= cmd.wheel_index;
      m     <= ONE;
      if (cmd.operation == mwm_pkg::OP_MIX) begin
        lane[0] <= f + s + r;
        lane[1] <= f - s - r;
        lane[2] <= f - s + r;
        lane[3] <= f + s - r;
      end else if (cmd.operation == mwm_pkg::OP_SET && !cmd.wheel_index[2]) begin
        lane[cmd.wheel_index[1:0]] <= ws_clamp;
      end
    end
    if (ctl.scan && sel_mag > m) m <= sel_mag;
    if (ctl.mul) prod <= NW'(sel_mag) * NW'(DMAX);
  end

  mwm_div #(.NW(NW), .DW(MW), .QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (prod),
    .den   (m),
    .done  (div_done),
    .quot  (quot)
  );

  // wheel state, idle counter and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
        wduty[i] <= '0;
        wrev[i]  <= 1'b0;
      end
      idle_ticks <= '0;
      wd_fired   <= 1'b0;
      ignored    <= 1'b0;
    end else begin
      if (ctl.write_wheel) begin
        wduty[ctl.wheel] <= quot;
        wrev[ctl.wheel]  <= sel_lane[SW-1];
      end
      if (ctl.apply) begin
        wd_fired <= 1'b0;
        ignored  <= (op_r == mwm_pkg::OP_SET) && idx_r[2];
        if (op_r == mwm_pkg::OP_TICK) begin
          if (tick_next > {1'b0, timeout}) begin
            for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
              wduty[i] <= '0;
              wrev[i]  <= 1'b0;
            end
            idle_ticks <= '0;
            wd_fired   <= 1'b1;
          end else begin
            idle_ticks <= tick_next[TW-1:0];
          end
        end else begin
          idle_ticks <= '0;
          if (op_r == mwm_pkg::OP_STOP) begin
            for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
              wduty[i] <= '0;
              wrev[i]  <= 1'b0;
            end
          end
        end
      end
    end
  end

  // pin duties, masked to the 8-bit output fields
  logic [7:0]    fwd [mwm_pkg::WHEELS];
  logic [7:0]    rev [mwm_pkg::WHEELS];
  logic [QW+7:0] ext [mwm_pkg::WHEELS];

  always_comb begin
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      ext[i] = {8'b0, wduty[i]};
      fwd[i] = wrev[i] ? 8'd0 : ext[i][7:0];
      rev[i] = wrev[i] ? ext[i][7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_valid <= 1'b0;
    end else if (ctl.emit) begin
      duty_valid <= 1'b1;
    end else if (!duty_stall) begin
      duty_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      duty.fl_fwd_duty      <= fwd[0];
      duty.fl_rev_duty      <= rev[0];
      duty.fr_fwd_duty      <= fwd[1];
      duty.fr_rev_duty      <= rev[1];
      duty.rl_fwd_duty      <= fwd[2];
      duty.rl_rev_duty      <= rev[2];
      duty.rr_fwd_duty      <= fwd[3];
      duty.rr_rev_duty      <= rev[3];
      duty.watchdog_stopped <= wd_fired;
      duty.index_ignored    <= ignored;
    end
  end

  // quotient never exceeds full scale because m bounds every magnitude
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.write_wheel |-> quot <= DMAX)
    else $error("wheel duty above full scale");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.apply && op_r == mwm_pkg::OP_STOP |=>
      wduty[0] == '0 && wduty[1] == '0 && wduty[2] == '0 && wduty[3] == '0)
    else $error("stop left a wheel running");

  a_idle_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.apply && op_r == mwm_pkg::OP_TICK |=> idle_ticks <= $past(timeout))
    else $error("idle counter passed the timeout");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

// ===== design/mwm_ctrl.sv =====
// sequencer for the mixer: capture, max scan, per-wheel multiply/divide,
// state update and result hand-off; uses mwm_pkg types and codes
module mwm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  mwm_pkg::dp_status_t status,
  output mwm_pkg::ctrl_cmd_t  ctl
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_DIVGO   = 3'd4;
  localparam logic [2:0] S_DIVWAIT = 3'd5;
  localparam logic [2:0] S_APPLY   = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] wheel, wheel_next;

  assign cmd_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    ctl        = '0;
    ctl.wheel  = wheel;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.op == mwm_pkg::OP_MIX) begin
          wheel_next = 2'd0;
          state_next = S_SCAN;
        end else if (status.op == mwm_pkg::OP_SET && status.index_ok) begin
          wheel_next = status.sel;
          state_next = S_MUL;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SCAN: begin
        ctl.scan   = 1'b1;
        wheel_next = wheel + 2'd1;
        if (wheel == 2'd3) state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (status.div_done) begin
          ctl.write_wheel = 1'b1;
          // a mix drives all four wheels, a single-wheel set only one
          if (status.op == mwm_pkg::OP_MIX && wheel != 2'd3) begin
            wheel_next = wheel + 2'd1;
            state_next = S_MUL;
          end else begin
            state_next = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        ctl.apply  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel <= 2'd0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
    end
  end

endmodule

// ===== design/mecanum_wheel_mixer_pwm.sv =====
// Mecanum wheel mixer with H-bridge duty outputs.
// Command channel (cmd_valid / cmd_stall / cmd): one transaction per command:
// mix three axes, set one wheel, stop all, or one watchdog tick.
// Duty channel (duty_valid / duty_stall / duty): exactly one transaction per
// command, holding all eight pin duties after it plus the two flags.
// A mix scans the four wheel lanes for the largest magnitude, then multiplies
// and divides for each wheel in turn; a single-wheel set does one multiply
// and divide; stop, tick and a set with a bad index go to the state update.
// The shared restoring divider gives one quotient bit a cycle; one command is
// in work at a time, and the next is taken once the result sits in the output
// register. A stalled result holds in the output register; the next command
// may be accepted meanwhile, and its result waits until the previous one is
// taken. Reset (rst, synchronous) stops all wheels, clears the idle counter,
// empties the output register and sets timeout_ticks to 500. timeout_ticks is
// written over the APB port at byte address 0; the user must write it only
// while idle, the block itself does not enforce it. mwm_pkg holds the types;
// mwm_ctrl sequences mwm_datapath.
module mecanum_wheel_mixer_pwm #(
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF,
  parameter int DUTY_MAX  = mwm_pkg::DUTY_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  mwm_pkg::cmd_item_t            cmd,
  output logic                          duty_valid,
  input  logic                          duty_stall,
  output mwm_pkg::duty_item_t           duty,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mwm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mwm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [mwm_pkg::TIMEOUT_W-1:0] timeout_ticks;
  mwm_pkg::ctrl_cmd_t            ctl;
  mwm_pkg::dp_status_t           status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mwm_pkg::REG_TIMEOUT) ?
                  mwm_pkg::PDATA_W'(timeout_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= mwm_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == mwm_pkg::REG_TIMEOUT) begin
      timeout_ticks <= pwdata[mwm_pkg::TIMEOUT_W-1:0];
    end
  end

  mwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctl       (ctl)
  );

  mwm_datapath #(.FRAC_BITS(FRAC_BITS), .DUTY_MAX(DUTY_MAX)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .status     (status),
    .cmd        (cmd),
    .timeout    (timeout_ticks),
    .duty_valid (duty_valid),
    .duty_stall (duty_stall),
    .duty       (duty)
  );

endmodule

// ===== tb/tb_mecanum_wheel_mixer_pwm.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mecanum_wheel_mixer_pwm: a directed table, then random command
// streams under several idle/stall mixes and timeout settings, checked by typed rows or a duty predictor.
// Depends on mwm_pkg and the mecanum_wheel_mixer_pwm RTL only.
module tb_mecanum_wheel_mixer_pwm;

  localparam int ONE_Q        = 1 << mwm_pkg::FRAC_BITS_DEF;
  localparam int DUTY_FULL    = mwm_pkg::DUTY_MAX_DEF;
  localparam int WHEELS       = mwm_pkg::WHEELS;
  localparam int RANDOM_ITEMS = 1100;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 80;

  logic                         clk;
  logic                         rst;
  logic                         cmd_valid;
  logic                         cmd_stall;
  mwm_pkg::cmd_item_t           cmd;
  logic                         duty_valid;
  logic                         duty_stall;
  mwm_pkg::duty_item_t          duty;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [mwm_pkg::PADDR_W-1:0]  paddr;
  logic [mwm_pkg::PDATA_W-1:0]  pwdata;
  logic [mwm_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  mecanum_wheel_mixer_pwm DUT (.*);

  typedef struct {
    mwm_pkg::cmd_item_t  item;
    bit                  typed;
    mwm_pkg::duty_item_t duties;
  } dir_row_t;

  // predictor state
  bit          wheel_rev [WHEELS];
  int unsigned wheel_lvl [WHEELS];
  int unsigned idle_count;
  int unsigned timeout_shadow;

  mwm_pkg::duty_item_t pending_duties [$];
  dir_row_t            directed_rows [$];
  int                  errors;
  bit                  hold_request;
  int                  sender_idle_pct;
  int                  stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_mecanum_wheel_mixer_pwm: done, errors");
    $finish;
  end

  function automatic void stop_wheels();
    for (int i = 0; i < WHEELS; i++) begin
      wheel_rev[i] = 1'b0;
      wheel_lvl[i] = 0;
    end
  endfunction

  function automatic void set_wheel(int w, int v, int unsigned m);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    wheel_rev[w] = v < 0;
    wheel_lvl[w] = (mag * DUTY_FULL) / m;
  endfunction

  function automatic logic [7:0] pin_duty(int w, bit rev_pin);
    return (wheel_rev[w] == rev_pin) ? 8'(wheel_lvl[w]) : 8'd0;
  endfunction

  function automatic mwm_pkg::duty_item_t predict_duties(mwm_pkg::cmd_item_t c);
    mwm_pkg::duty_item_t r;
    int                  v [WHEELS];
    int                  f;
    int                  rot;
    int                  s;
    int                  ws;
    int unsigned         m;
    int unsigned         n;
    r = '0;
    case (c.operation)
      mwm_pkg::OP_MIX: begin
        f = int'(c.forward_speed);
        rot = int'(c.rotate_speed);
        s = int'(c.strafe_speed);
        v[0] = f + s + rot;
        v[1] = f - s - rot;
        v[2] = f - s + rot;
        v[3] = f + s - rot;
        m = ONE_Q;
        for (int i = 0; i < WHEELS; i++)
          if (((v[i] < 0) ? -v[i] : v[i]) > m) m = (v[i] < 0) ? -v[i] : v[i];
        for (int i = 0; i < WHEELS; i++) set_wheel(i, v[i], m);
        idle_count = 0;
      end
      mwm_pkg::OP_SET: begin
        ws = int'(c.wheel_speed);
        if (ws > ONE_Q) ws = ONE_Q;
        if (ws < -ONE_Q) ws = -ONE_Q;
        if (c.wheel_index < WHEELS) set_wheel(c.wheel_index, ws, ONE_Q);
        else r.index_ignored = 1'b1;
        idle_count = 0;
      end
      mwm_pkg::OP_STOP: begin
        stop_wheels();
        idle_count = 0;
      end
      default: begin
        n = idle_count + 1;
        if (n > timeout_shadow) begin
          stop_wheels();
          idle_count = 0;
          r.watchdog_stopped = 1'b1;
        end else begin
          idle_count = n & 32'hFFFF;
        end
      end
    endcase
    r.fl_fwd_duty = pin_duty(0, 1'b0);
    r.fl_rev_duty = pin_duty(0, 1'b1);
    r.fr_fwd_duty = pin_duty(1, 1'b0);
    r.fr_rev_duty = pin_duty(1, 1'b1);
    r.rl_fwd_duty = pin_duty(2, 1'b0);
    r.rl_rev_duty = pin_duty(2, 1'b1);
    r.rr_fwd_duty = pin_duty(3, 1'b0);
    r.rr_rev_duty = pin_duty(3, 1'b1);
    return r;
  endfunction

  function automatic mwm_pkg::cmd_item_t cmd_of(logic [1:0] op, int f, int rot, int s,
                                                int idx, int ws);
    mwm_pkg::cmd_item_t c;
    c.operation = op;
    c.forward_speed = 16'(f);
    c.rotate_speed = 16'(rot);
    c.strafe_speed = 16'(s);
    c.wheel_index = 3'(idx);
    c.wheel_speed = 16'(ws);
    return c;
  endfunction

  function automatic void add_row(mwm_pkg::cmd_item_t c, bit typed, mwm_pkg::duty_item_t d);
    dir_row_t row;
    row.item = c;
    row.typed = typed;
    row.duties = d;
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(8192)) - 4096);
      2: return 16'(int'($urandom_range(64)) - 32);
      3: begin
        case ($urandom_range(5))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h1000;
          3: return 16'hF000;
          4: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'(int'($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic mwm_pkg::cmd_item_t rand_item(logic [1:0] op);
    mwm_pkg::cmd_item_t c;
    c.operation = op;
    c.forward_speed = rand_speed();
    c.rotate_speed = rand_speed();
    c.strafe_speed = rand_speed();
    c.wheel_index = ($urandom_range(3) != 0) ? 3'($urandom_range(3)) : 3'($urandom_range(4, 7));
    c.wheel_speed = rand_speed();
    return c;
  endfunction

  function automatic void note_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_duties(mwm_pkg::duty_item_t got);
    mwm_pkg::duty_item_t want;
    if (pending_duties.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t: unexpected duty transaction %h", $time, got);
      return;
    end
    want = pending_duties.pop_front();
    note_field("fl_fwd_duty", want.fl_fwd_duty, got.fl_fwd_duty);
    note_field("fl_rev_duty", want.fl_rev_duty, got.fl_rev_duty);
    note_field("fr_fwd_duty", want.fr_fwd_duty, got.fr_fwd_duty);
    note_field("fr_rev_duty", want.fr_rev_duty, got.fr_rev_duty);
    note_field("rl_fwd_duty", want.rl_fwd_duty, got.rl_fwd_duty);
    note_field("rl_rev_duty", want.rl_rev_duty, got.rl_rev_duty);
    note_field("rr_fwd_duty", want.rr_fwd_duty, got.rr_fwd_duty);
    note_field("rr_rev_duty", want.rr_rev_duty, got.rr_rev_duty);
    note_field("watchdog_stopped", want.watchdog_stopped, got.watchdog_stopped);
    note_field("index_ignored", want.index_ignored, got.index_ignored);
  endfunction

  // called at a rising edge; returns at the edge that accepted the transaction
  task automatic send_item(mwm_pkg::cmd_item_t c, bit typed,
                           mwm_pkg::duty_item_t typed_duties);
    mwm_pkg::duty_item_t predicted;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    predicted = predict_duties(c);
    pending_duties.push_back(typed ? typed_duties : predicted);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic wait_drained();
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write then read back timeout_ticks; cmd_valid must already be low
  task automatic program_timeout(int unsigned value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= mwm_pkg::PADDR_W'({mwm_pkg::REG_TIMEOUT, 2'b00});
    pwdata <= mwm_pkg::PDATA_W'(value & 32'hFFFF);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    timeout_shadow = value & 32'hFFFF;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== 16'(timeout_shadow)) begin
      errors++;
      if (errors <= 10)
        $display("%0t: timeout_ticks readback, expected %0d, got %0d", $time, timeout_shadow,
                 prdata[15:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    int hold_count;
    hold_count = 0;
    duty_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count = HOLD_CYCLES;
      end
      if (hold_count > 0) begin
        hold_count--;
        duty_stall <= 1'b1;
      end else begin
        duty_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && duty_valid === 1'b1 && duty_stall === 1'b0) check_duties(duty);
  end

  initial begin
    mwm_pkg::duty_item_t zero_duties;
    mwm_pkg::duty_item_t fired_duties;
    mwm_pkg::duty_item_t ignored_duties;
    int unsigned         phase_timeout [PHASES];
    int                  items_per_phase;
    int                  sent;
    int                  roll;
    int                  burst;
    logic [1:0]          op;

    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    hold_request = 1'b0;
    sender_idle_pct = 0;
    stall_pct = 0;

    stop_wheels();
    idle_count = 0;
    timeout_shadow = mwm_pkg::TIMEOUT_RESET;

    zero_duties = '0;
    fired_duties = '0;
    fired_duties.watchdog_stopped = 1'b1;
    ignored_duties = '0;
    ignored_duties.index_ignored = 1'b1;

    // directed table, run with timeout_ticks = 2
    add_row(cmd_of(mwm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1'b1, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_MIX, 4096, 0, 0, 0, 0), 1'b1,
            '{255, 0, 255, 0, 255, 0, 255, 0, 0, 0});
    add_row(cmd_of(mwm_pkg::OP_MIX, -4096, 0, 0, 0, 0), 1'b1,
            '{0, 255, 0, 255, 0, 255, 0, 255, 0, 0});
    add_row(cmd_of(mwm_pkg::OP_MIX, -32768, -32768, -32768, 0, 0), 1'b1,
            '{0, 255, 85, 0, 0, 85, 0, 85, 0, 0});
    add_row(cmd_of(mwm_pkg::OP_MIX, 32767, 32767, 32767, 7, -1), 1'b1,
            '{255, 0, 0, 85, 85, 0, 85, 0, 0, 0});
    // every wheel rounds to zero, the two negative ones keep reverse direction
    add_row(cmd_of(mwm_pkg::OP_MIX, 0, 0, -1, 0, 0), 1'b1, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_MIX, 0, 4096, 0, 0, 0), 1'b1,
            '{255, 0, 0, 255, 255, 0, 0, 255, 0, 0});
    add_row(cmd_of(mwm_pkg::OP_MIX, 0, 0, 4096, 0, 0), 1'b1,
            '{255, 0, 0, 255, 0, 255, 255, 0, 0, 0});
    add_row(cmd_of(mwm_pkg::OP_MIX, 2048, 1024, -512, 0, 0), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 0, 32767), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 1, -32768), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 2, 4095), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 3, -4096), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 3, -10), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 16'h5A5A, 16'hA5A5, 16'hFFFF, 7, 1234), 1'b0,
            zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 0, 0, 0, 4, -1), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_STOP, -1, -1, -1, 7, -1), 1'b1, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_MIX, 1000, -300, 200, 0, 0), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1'b0, zero_duties);
    // third idle tick passes the timeout
    add_row(cmd_of(mwm_pkg::OP_TICK, 0, 0, 0, 0, 0), 1'b1, fired_duties);
    add_row(cmd_of(mwm_pkg::OP_TICK, 123, 456, 789, 5, 99), 1'b1, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_SET, 16'h8001, 16'h7FFE, 16'h0F0F, 6, -1), 1'b1,
            ignored_duties);
    add_row(cmd_of(mwm_pkg::OP_MIX, -32768, 32767, 0, 0, 0), 1'b0, zero_duties);
    add_row(cmd_of(mwm_pkg::OP_STOP, 0, 0, 0, 0, 0), 1'b1, zero_duties);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    program_timeout(2);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].duties);
    cmd_valid <= 1'b0;
    wait_drained();

    phase_timeout = '{1, 0, 65535, 3, $urandom_range(2, 12), 500, 1, $urandom_range(1, 65535)};
    items_per_phase = RANDOM_ITEMS / PHASES;

    for (int p = 0; p < PHASES; p++) begin
      program_timeout(phase_timeout[p]);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
          hold_request = 1'b1;
        end
        1: begin
          sender_idle_pct = 72;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 72;
        end
        default: begin
          sender_idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      @(posedge clk);
      sent = 0;
      while (sent < items_per_phase) begin
        roll = $urandom_range(99);
        if (roll < 35) op = mwm_pkg::OP_MIX;
        else if (roll < 60) op = mwm_pkg::OP_SET;
        else if (roll < 68) op = mwm_pkg::OP_STOP;
        else op = mwm_pkg::OP_TICK;
        burst = 1;
        // runs of idle ticks long enough to trip a short watchdog
        if (op == mwm_pkg::OP_TICK && $urandom_range(99) < 20)
          burst = $urandom_range(1, (timeout_shadow > 38) ? 40 : timeout_shadow + 2);
        repeat (burst) begin
          send_item(rand_item(op), 1'b0, zero_duties);
          sender_gap();
          sent++;
        end
      end
      cmd_valid <= 1'b0;
      wait_drained();
    end

    stall_pct = 0;
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_duties.size() == 0) begin
      $display("tb_mecanum_wheel_mixer_pwm: done, clean");
    end else begin
      $display("tb_mecanum_wheel_mixer_pwm: done, errors");
    end
    $finish;
  end

endmodule
